// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the compensation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define PTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the following cycle.
`define PTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ptc_pkg.sv =====
// Types, constants and helpers of the pressure and temperature compensation.
`default_nettype none
package ptc_pkg;

    // Calibration words, unpacked from the configuration registers.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_cal;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP   = 2'd0;
    localparam logic [1:0] CFG_PLOW   = 2'd1;
    localparam logic [1:0] CFG_PHIGH  = 2'd2;
    localparam logic [1:0] CFG_PLAST  = 2'd3;

    // Pipeline depths.
    localparam int FRONT_STAGES = 10;
    localparam int DIV_STAGES   = 32;
    localparam int POST_STAGES  = 4;
    localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + POST_STAGES;

    // Arithmetic right shift of a 32-bit word.
    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    // Sign-extend a 16-bit coefficient.
    function automatic logic [31:0] sx16(input logic [15:0] w);
        sx16 = {{16{w[15]}}, w};
    endfunction

    // Zero-extend a 16-bit coefficient.
    function automatic logic [31:0] ux16(input logic [15:0] w);
        ux16 = {16'd0, w};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ptc_front.sv =====
// Temperature, divisor and pressure numerator pipeline.
`default_nettype none
module ptc_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire ptc_pkg::t_cal i_cal,
    input  wire logic         i_valid,
    input  wire logic [19:0]  i_raw_pressure,
    input  wire logic [19:0]  i_raw_temperature,
    output logic              o_valid,
    output logic [31:0]       o_dividend,
    output logic [31:0]       o_divisor,
    output logic [31:0]       o_temp,
    output logic              o_post2,
    output logic              o_zero
);
    import ptc_pkg::*;

    logic [FRONT_STAGES-1:0] r_vld;
    logic [19:0] r_adcp1, r_adcp2, r_adcp3, r_adcp4, r_adcp5, r_adcp6, r_adcp7, r_adcp8;
    logic [31:0] r1_x1, r1_d;
    logic [31:0] r2_ma, r2_dd;
    logic [31:0] r3_a, r3_mb;
    logic [31:0] r4_fine;
    logic [31:0] r5_pa, r5_q;
    logic [31:0] r6_sq, r6_ap5, r6_p2a;
    logic [31:0] r7_b1, r7_p3s, r7_ap5, r7_p2a;
    logic [31:0] r8_b3, r8_a1;
    logic [31:0] r9_mult, r9_num;
    logic [31:0] r10_div, r10_num;
    logic [31:0] r5_temp, r6_temp, r7_temp, r8_temp, r9_temp, r10_temp;
    logic [31:0] n_fine5;

    // Advance the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_valid};
        end
    end

    assign n_fine5 = (r4_fine << 2) + r4_fine + 32'd128;

    // Stages; user keeps calibration steady while items are in flight.
    always_ff @(posedge i_clk) begin
        r1_x1   <= 32'(i_raw_temperature >> 3) - {15'd0, i_cal.t1, 1'b0};
        r1_d    <= 32'(i_raw_temperature >> 4) - ux16(i_cal.t1);
        r_adcp1 <= i_raw_pressure;

        r2_ma   <= r1_x1 * sx16(i_cal.t2);
        r2_dd   <= r1_d * r1_d;
        r_adcp2 <= r_adcp1;

        r3_a    <= asr32(r2_ma, 11);
        r3_mb   <= asr32(r2_dd, 12) * sx16(i_cal.t3);
        r_adcp3 <= r_adcp2;

        r4_fine <= r3_a + asr32(r3_mb, 14);
        r_adcp4 <= r_adcp3;

        r5_temp <= asr32(n_fine5, 8);
        r5_pa   <= asr32(r4_fine, 1) - 32'd64000;
        r5_q    <= asr32(asr32(r4_fine, 1) - 32'd64000, 2);
        r_adcp5 <= r_adcp4;

        r6_sq   <= r5_q * r5_q;
        r6_ap5  <= r5_pa * sx16(i_cal.p5);
        r6_p2a  <= sx16(i_cal.p2) * r5_pa;
        r6_temp <= r5_temp;
        r_adcp6 <= r_adcp5;

        r7_b1   <= asr32(r6_sq, 11) * sx16(i_cal.p6);
        r7_p3s  <= sx16(i_cal.p3) * asr32(r6_sq, 13);
        r7_ap5  <= r6_ap5;
        r7_p2a  <= r6_p2a;
        r7_temp <= r6_temp;
        r_adcp7 <= r_adcp6;

        r8_b3   <= asr32(r7_b1 + (r7_ap5 << 1), 2) + (sx16(i_cal.p4) << 16);
        r8_a1   <= asr32(asr32(r7_p3s, 3) + asr32(r7_p2a, 1), 18);
        r8_temp <= r7_temp;
        r_adcp8 <= r_adcp7;

        r9_mult <= (32'd32768 + r8_a1) * ux16(i_cal.p1);
        r9_num  <= ((32'd1048576 - {12'd0, r_adcp8}) - asr32(r8_b3, 12)) * 32'd3125;
        r9_temp <= r8_temp;

        r10_div  <= asr32(r9_mult, 15);
        r10_num  <= r9_num;
        r10_temp <= r9_temp;
    end

    // Pick the dividend form that keeps the top bit.
    assign o_valid    = r_vld[FRONT_STAGES-1];
    assign o_post2    = r10_num[31];
    assign o_dividend = r10_num[31] ? r10_num : {r10_num[30:0], 1'b0};
    assign o_divisor  = r10_div;
    assign o_zero     = (r10_div == 32'd0);
    assign o_temp     = r10_temp;

endmodule
`default_nettype wire

// ===== rtl/ptc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module ptc_div #(
    parameter int W_SIDE = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [31:0]       i_dividend,
    input  wire logic [31:0]       i_divisor,
    input  wire logic [W_SIDE-1:0] i_side,
    output logic                   o_valid,
    output logic [31:0]            o_quotient,
    output logic [W_SIDE-1:0]      o_side
);
    import ptc_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [31:0]       r_rem  [DIV_STAGES];
    logic [31:0]       r_num  [DIV_STAGES];
    logic [31:0]       r_quo  [DIV_STAGES];
    logic [31:0]       r_dvs  [DIV_STAGES];
    logic [W_SIDE-1:0] r_side [DIV_STAGES];

    // Advance the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [31:0]       rem_in, num_in, quo_in, dvs_in;
        logic [W_SIDE-1:0] side_in;
        logic [32:0]       n_trial;
        logic              n_ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign num_in  = i_dividend;
            assign quo_in  = '0;
            assign dvs_in  = i_divisor;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign num_in  = r_num[k-1];
            assign quo_in  = r_quo[k-1];
            assign dvs_in  = r_dvs[k-1];
            assign side_in = r_side[k-1];
        end

        // Shift in one dividend bit and subtract where it fits.
        assign n_trial = {rem_in, num_in[31]};
        assign n_ge    = (n_trial >= {1'b0, dvs_in});

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_ge ? 32'(n_trial - {1'b0, dvs_in}) : n_trial[31:0];
            r_num[k]  <= {num_in[30:0], 1'b0};
            r_quo[k]  <= {quo_in[30:0], n_ge};
            r_dvs[k]  <= dvs_in;
            r_side[k] <= side_in;
        end
    end

    assign o_valid    = r_vld[DIV_STAGES-1];
    assign o_quotient = r_quo[DIV_STAGES-1];
    assign o_side     = r_side[DIV_STAGES-1];

`include "assert_macros.svh"
    `PTC_ASSERT_IMPL(a_div_latency, i_clk, i_rst_n, o_valid, $past(i_valid, DIV_STAGES))

endmodule
`default_nettype wire

// ===== rtl/ptc_post.sv =====
// Quadratic pressure correction and output register.
`default_nettype none
module ptc_post (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ptc_pkg::t_cal i_cal,
    input  wire logic          i_valid,
    input  wire logic [31:0]   i_quotient,
    input  wire logic [31:0]   i_temp,
    input  wire logic          i_post2,
    input  wire logic          i_zero,
    output logic               o_valid,
    output logic [31:0]        o_temp,
    output logic [31:0]        o_pressure
);
    import ptc_pkg::*;

    logic [POST_STAGES-1:0] r_vld;
    logic [31:0] r1_p, r2_p, r3_p;
    logic [31:0] r2_sqx, r2_m8;
    logic [31:0] r3_a, r3_b;
    logic [31:0] r1_t, r2_t, r3_t, r4_t;
    logic        r1_z, r2_z, r3_z;
    logic [31:0] r4_p;
    logic [31:0] n_x;

    // Advance the valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[POST_STAGES-2:0], i_valid};
        end
    end

    assign n_x = r1_p >> 3;

    // Finish the quotient, then apply the p7..p9 correction, or output zero for a zero divisor.
    always_ff @(posedge i_clk) begin
        r1_p   <= i_post2 ? {i_quotient[30:0], 1'b0} : i_quotient;
        r1_z   <= i_zero;
        r1_t   <= i_temp;

        r2_sqx <= n_x * n_x;
        r2_m8  <= (r1_p >> 2) * sx16(i_cal.p8);
        r2_p   <= r1_p;
        r2_z   <= r1_z;
        r2_t   <= r1_t;

        r3_a   <= asr32(sx16(i_cal.p9) * (r2_sqx >> 13), 12);
        r3_b   <= asr32(r2_m8, 13);
        r3_p   <= r2_p;
        r3_z   <= r2_z;
        r3_t   <= r2_t;

        r4_p   <= r3_z ? 32'd0 : r3_p + asr32(r3_a + r3_b + sx16(i_cal.p7), 4);
        r4_t   <= r3_t;
    end

    assign o_valid    = r_vld[POST_STAGES-1];
    assign o_temp     = r4_t;
    assign o_pressure = r4_p;

`include "assert_macros.svh"
    `PTC_ASSERT_NEXT(a_zero_div, i_clk, i_rst_n, r_vld[POST_STAGES-2] && r3_z, r4_p == 32'd0)

endmodule
`default_nettype wire

// ===== rtl/pressure_temperature_compensation.sv =====
// Top level of the barometric pressure and temperature compensation.
// Throughput: one sample pair per cycle; busy stays low, start is taken every cycle.
// The depth is set by the 32-stage divider plus 10 front and 4 correction stages.
// Synchronous active-low reset clears the calibration registers and all valid bits.
// Results are strobed for one cycle and cannot be held off.
`default_nettype none
module pressure_temperature_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [19:0] i_raw_pressure,
    input  wire logic [19:0] i_raw_temperature,
    output logic             o_strobe,
    output logic [31:0]      o_temperature_centi,
    output logic [31:0]      o_pressure_pa,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import ptc_pkg::*;

    logic [47:0] r_cfg_temp;
    logic [63:0] r_cfg_plow;
    logic [63:0] r_cfg_phigh;
    logic [15:0] r_cfg_plast;
    t_cal        cal;

    logic        f_valid, f_post2, f_zero;
    logic [31:0] f_dividend, f_divisor, f_temp;
    logic        d_valid;
    logic [31:0] d_quotient;
    logic [33:0] d_side;

    // Write the calibration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp  <= '0;
            r_cfg_plow  <= '0;
            r_cfg_phigh <= '0;
            r_cfg_plast <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP:  r_cfg_temp  <= i_cfg_data[47:0];
                CFG_PLOW:  r_cfg_plow  <= i_cfg_data;
                CFG_PHIGH: r_cfg_phigh <= i_cfg_data;
                CFG_PLAST: r_cfg_plast <= i_cfg_data[15:0];
                default:   r_cfg_plast <= r_cfg_plast;
            endcase
        end
    end

    // Unpack the coefficients.
    assign cal.t1 = r_cfg_temp[15:0];
    assign cal.t2 = r_cfg_temp[31:16];
    assign cal.t3 = r_cfg_temp[47:32];
    assign cal.p1 = r_cfg_plow[15:0];
    assign cal.p2 = r_cfg_plow[31:16];
    assign cal.p3 = r_cfg_plow[47:32];
    assign cal.p4 = r_cfg_plow[63:48];
    assign cal.p5 = r_cfg_phigh[15:0];
    assign cal.p6 = r_cfg_phigh[31:16];
    assign cal.p7 = r_cfg_phigh[47:32];
    assign cal.p8 = r_cfg_phigh[63:48];
    assign cal.p9 = r_cfg_plast;

    assign busy = 1'b0;

    ptc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (cal),
        .i_valid           (start && !busy),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_valid           (f_valid),
        .o_dividend        (f_dividend),
        .o_divisor         (f_divisor),
        .o_temp            (f_temp),
        .o_post2           (f_post2),
        .o_zero            (f_zero)
    );

    ptc_div #(.W_SIDE(34)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .i_dividend (f_dividend),
        .i_divisor  (f_divisor),
        .i_side     ({f_temp, f_post2, f_zero}),
        .o_valid    (d_valid),
        .o_quotient (d_quotient),
        .o_side     (d_side)
    );

    ptc_post u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cal      (cal),
        .i_valid    (d_valid),
        .i_quotient (d_quotient),
        .i_temp     (d_side[33:2]),
        .i_post2    (d_side[1]),
        .i_zero     (d_side[0]),
        .o_valid    (o_strobe),
        .o_temp     (o_temperature_centi),
        .o_pressure (o_pressure_pa)
    );

`include "assert_macros.svh"
    `PTC_ASSERT_IMPL(a_latency, i_clk, i_rst_n, o_strobe, $past(start, LATENCY))

endmodule
`default_nettype wire
